// ===== rtl/mbvf_pkg.sv =====
// Types, constants and datapath functions of the meter BCD value format codec.
// Used by mbvf_pipe_reg and meter_bcd_value_format_codec_top; no dependencies.
package mbvf_pkg;

  typedef enum logic [2:0] {
    OP_ENC02 = 3'd0,
    OP_DEC02 = 3'd1,
    OP_ENC03 = 3'd2,
    OP_DEC03 = 3'd3,
    OP_ENC25 = 3'd4,
    OP_DEC25 = 3'd5
  } mbvf_op_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] operand_word;
  } mbvf_in_t;

  typedef struct packed {
    logic [31:0] result_word;
    logic        out_of_range;
  } mbvf_out_t;

  typedef struct packed {
    logic [2:0]  op;
    logic        neg;
    logic [31:0] bin;
    logic [39:0] bcd;
    logic [27:0] dig;
    logic [26:0] scale;
    logic [7:0]  p0;
    logic [7:0]  p1;
    logic [7:0]  p2;
    logic [7:0]  p3;
    logic [14:0] lo;
    logic [10:0] hi;
    logic [27:0] v;
    logic [54:0] prod;
  } mbvf_stg_t;

  localparam logic [31:0] MagLimit = 32'h7FFF_FFFF;

  localparam logic [26:0] Coef02 [8] = '{
    27'd100000000, 27'd10000000, 27'd1000000, 27'd100000,
    27'd10000, 27'd1000, 27'd100, 27'd10
  };

  // Eight shift-and-add-3 steps over ten BCD digits.
  function automatic logic [39:0] dabble8(input logic [39:0] bcd, input logic [7:0] bits);
    logic [39:0] r;
    r = bcd;
    for (int s = 7; s >= 0; s--) begin
      for (int n = 0; n < 10; n++) begin
        if (r[4*n +: 4] >= 4'd5) begin
          r[4*n +: 4] = r[4*n +: 4] + 4'd3;
        end
      end
      r = {r[38:0], bits[s]};
    end
    return r;
  endfunction

  function automatic mbvf_stg_t prep(input mbvf_in_t in);
    mbvf_stg_t s;
    logic [31:0] w;
    w = in.operand_word;
    s = '0;
    s.op  = in.opcode;
    s.bin = w[31] ? (32'd0 - w) : w;
    unique case (in.opcode)
      OP_DEC02: begin
        s.neg   = w[12];
        s.dig   = {16'd0, w[11:0]};
        s.scale = Coef02[w[15:13]];
      end
      OP_DEC03: begin
        s.neg   = w[28];
        s.dig   = w[27:0];
        s.scale = w[30] ? 27'd100000 : 27'd100;
      end
      OP_DEC25: begin
        s.neg   = w[23];
        s.dig   = {5'd0, w[22:0]};
        s.scale = 27'd1;
      end
      default: begin
        s.neg = w[31];
      end
    endcase
    return s;
  endfunction

  function automatic logic [7:0] pair(input logic [7:0] d);
    return {4'd0, d[3:0]} + {4'd0, d[7:4]} * 8'd10;
  endfunction

  function automatic mbvf_out_t finish(input mbvf_stg_t s);
    mbvf_out_t o;
    logic [11:0] d3;
    logic [2:0]  code;
    logic        sat;
    logic [31:0] mag;
    o = '0;
    unique case (s.op)
      OP_ENC02: begin
        priority if (s.bcd[39:36] != 4'd0) begin
          d3 = s.bcd[39:28]; code = 3'd1;
        end else if (s.bcd[35:32] != 4'd0) begin
          d3 = s.bcd[35:24]; code = 3'd2;
        end else if (s.bcd[31:28] != 4'd0) begin
          d3 = s.bcd[31:20]; code = 3'd3;
        end else if (s.bcd[27:24] != 4'd0) begin
          d3 = s.bcd[27:16]; code = 3'd4;
        end else if (s.bcd[23:20] != 4'd0) begin
          d3 = s.bcd[23:12]; code = 3'd5;
        end else if (s.bcd[19:16] != 4'd0) begin
          d3 = s.bcd[19:8];  code = 3'd6;
        end else begin
          d3 = s.bcd[15:4];  code = 3'd7;
        end
        o.result_word = {16'd0, code, s.neg, d3};
      end
      OP_ENC03: begin
        if (s.bcd[39:36] != 4'd0) begin
          o.result_word = {3'b010, s.neg, 8'd0, s.bcd[39:20]};
        end else begin
          o.result_word = {3'b000, s.neg, s.bcd[35:8]};
        end
      end
      OP_ENC25: begin
        sat = (s.bcd[39:24] != 16'd0) || (s.bcd[23:20] >= 4'd8);
        o.result_word = {8'd0, s.neg, sat ? 23'h799999 : s.bcd[22:0]};
        o.out_of_range = sat;
      end
      OP_DEC02, OP_DEC03, OP_DEC25: begin
        sat = s.prod > {23'd0, MagLimit};
        mag = sat ? MagLimit : s.prod[31:0];
        o.result_word = s.neg ? (32'd0 - mag) : mag;
        o.out_of_range = sat;
      end
      default: begin
        o = '0;
      end
    endcase
    return o;
  endfunction

endpackage

// ===== rtl/mbvf_pipe_reg.sv =====
// One stage register of the codec pipeline with valid/ready flow control.
// Depends on mbvf_pkg for the stage record type.
module mbvf_pipe_reg import mbvf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      vld_i,
  output logic      rdy_o,
  input  mbvf_stg_t data_i,
  output logic      vld_o,
  input  logic      rdy_i,
  output mbvf_stg_t data_o
);

  logic      vld_q;
  mbvf_stg_t data_q;

  // fill a bubble or advance when downstream takes the request
  assign rdy_o = !vld_q || rdy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      data_q <= data_i;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

// ===== rtl/meter_bcd_value_format_codec_top.sv =====
// Meter BCD value format codec: six-stage pipeline, one request per cycle
// when not stalled; a request passes stage registers 0 to 4, then out_q.
// Throughput: 1 request per cycle unless stalled; binary-to-BCD runs 8 bits
// per stage over four stages; decode sums and the scale multiply share them.
// Reset: rst_ni asynchronously empties every stage; no other state.
module meter_bcd_value_format_codec_top import mbvf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  mbvf_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output mbvf_out_t out_data_o
);

  localparam int NumStg = 5;

  logic      vld   [NumStg];
  logic      rdy   [NumStg];
  mbvf_stg_t q     [NumStg];
  mbvf_stg_t d     [NumStg];
  logic      nxt_rdy [NumStg];

  logic      out_vld_q;
  mbvf_out_t out_q;
  logic      f_rdy;

  always_comb begin
    d[0] = prep(in_data_i);

    d[1] = q[0];
    d[1].bcd = dabble8(q[0].bcd, q[0].bin[31:24]);
    d[1].p0  = pair(q[0].dig[7:0]);
    d[1].p1  = pair(q[0].dig[15:8]);
    d[1].p2  = pair(q[0].dig[23:16]);
    d[1].p3  = {4'd0, q[0].dig[27:24]};

    d[2] = q[1];
    d[2].bcd = dabble8(q[1].bcd, q[1].bin[23:16]);
    d[2].lo  = {7'd0, q[1].p0} + {7'd0, q[1].p1} * 15'd100;
    d[2].hi  = {3'd0, q[1].p2} + {3'd0, q[1].p3} * 11'd100;

    d[3] = q[2];
    d[3].bcd = dabble8(q[2].bcd, q[2].bin[15:8]);
    d[3].v   = {13'd0, q[2].lo} + {17'd0, q[2].hi} * 28'd10000;

    d[4] = q[3];
    d[4].bcd  = dabble8(q[3].bcd, q[3].bin[7:0]);
    d[4].prod = {27'd0, q[3].v} * {28'd0, q[3].scale};
  end

  for (genvar i = 0; i < NumStg; i++) begin : g_stg
    if (i == NumStg - 1) begin : g_last
      assign nxt_rdy[i] = f_rdy;
    end else begin : g_mid
      assign nxt_rdy[i] = rdy[i+1];
    end
    mbvf_pipe_reg u_reg (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  ((i == 0) ? in_valid_i : vld[(i == 0) ? 0 : i-1]),
      .rdy_o  (rdy[i]),
      .data_i (d[i]),
      .vld_o  (vld[i]),
      .rdy_i  (nxt_rdy[i]),
      .data_o (q[i])
    );
  end

  assign in_ready_o = rdy[0];
  assign f_rdy      = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (f_rdy) begin
      out_vld_q <= vld[NumStg-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_rdy && vld[NumStg-1]) begin
      out_q <= finish(q[NumStg-1]);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> vld[0])
    else $error("input stalled with an empty first stage");

  a_last_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[NumStg-1] && !f_rdy |=> vld[NumStg-1] && $stable(q[NumStg-1]))
    else $error("last stage lost or changed a stalled request");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_of_range |->
      (out_data_o.result_word == 32'h7FFF_FFFF) ||
      (out_data_o.result_word == 32'h8000_0001) ||
      (out_data_o.result_word[31:24] == 8'd0))
    else $error("saturated result has an unexpected value");

endmodule
